// ===== src/scaled_glyph_rasterizer_defines.svh =====
// Assertion macros used by the rasterizer top level.
`ifndef SCALED_GLYPH_RASTERIZER_DEFINES_SVH
`define SCALED_GLYPH_RASTERIZER_DEFINES_SVH
`ifndef SYNTHESIS
`define SGR_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define SGR_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define SGR_ASSERT(lbl, clk, rst_n, prop, msg)
`define SGR_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg)
`endif
`endif

// ===== src/sgr_pkg.sv =====
package sgr_pkg;

  localparam int FrameWidthDefault  = 320;
  localparam int FrameHeightDefault = 200;
  localparam int GlyphCount         = 17;
  localparam int GlyphIdxW          = $clog2(GlyphCount);

  typedef enum logic [1:0] {
    OP_DRAW  = 2'd0,
    OP_READ  = 2'd1,
    OP_WRITE = 2'd2
  } opcode_e;

  typedef enum logic [2:0] {
    STAT_OK         = 3'd0,
    STAT_NO_GLYPH   = 3'd1,
    STAT_BOUNDS     = 3'd2,
    STAT_ZERO_SCALE = 3'd3,
    STAT_SKIPPED    = 3'd4
  } status_e;

  // Command from the sequencer to the cell walker.
  typedef struct packed {
    logic        start;
    logic [7:0]  ink;
    logic [7:0]  sx;
    logic [7:0]  sy;
    logic [63:0] bits;
  } walk_cmd_t;

  // Status from the cell walker.
  typedef struct packed {
    logic busy;
    logic last;
  } walk_stat_t;

  typedef struct packed {
    logic                 hit;
    logic [GlyphIdxW-1:0] idx;
  } glyph_hit_t;

  localparam logic [7:0] GlyphCode [GlyphCount] = '{
    8'h20, 8'h43, 8'h45, 8'h52, 8'h54, 8'h61, 8'h64, 8'h65, 8'h68,
    8'h69, 8'h6c, 8'h6d, 8'h6e, 8'h6f, 8'h70, 8'h72, 8'h74
  };

  // Row 0 sits in the top byte, leftmost pixel in the MSB of each row.
  localparam logic [63:0] GlyphBits [GlyphCount] = '{
    64'h0000000000000000,
    64'h3c66c0c0c0663c00,
    64'hfe6268786862fe00,
    64'hfc66667c786ce600,
    64'hfcb4303030307800,
    64'h0000780c7ccc7600,
    64'h1c0c0c7ccccc7600,
    64'h000078ccfcc07800,
    64'he0606c766666e600,
    64'h3000703030307800,
    64'h7030303030307800,
    64'h0000ecfed6c6c600,
    64'h0000f8cccccccc00,
    64'h000078cccccc7800,
    64'h0000dc66667c60f0,
    64'h0000dc766660f000,
    64'h10307c3030341800
  };

  function automatic glyph_hit_t glyph_find(input logic [7:0] code);
    glyph_hit_t res;
    res = '0;
    for (int k = 0; k < GlyphCount; k++) begin
      if (GlyphCode[k] == code) begin
        res.hit = 1'b1;
        res.idx = GlyphIdxW'(k);
      end
    end
    return res;
  endfunction

endpackage

// ===== src/sgr_in_if.sv =====
interface sgr_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic        first_of_string;
  logic [7:0]  char_code;
  logic [15:0] start_x;
  logic [15:0] start_y;
  logic [7:0]  color;
  logic [7:0]  scale_x;
  logic [7:0]  scale_y;
  logic [15:0] pixel_addr;

  modport source (
    output valid, opcode, first_of_string, char_code, start_x, start_y,
           color, scale_x, scale_y, pixel_addr,
    input  ready
  );
  modport sink (
    input  valid, opcode, first_of_string, char_code, start_x, start_y,
           color, scale_x, scale_y, pixel_addr,
    output ready
  );
endinterface

// ===== src/sgr_out_if.sv =====
interface sgr_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [7:0] pixel_value;

  modport source (output valid, status, pixel_value, input ready);
  modport sink (input valid, status, pixel_value, output ready);
endinterface

// ===== src/scaled_glyph_rasterizer.sv =====
// Channel   Dir  Role    Payload
// in_i      in   sink    opcode, first_of_string, char_code, start_x, start_y,
//                        color, scale_x, scale_y, pixel_addr
// out_o     out  source  status, pixel_value
//
// A draw transaction passes accept, check, setup and the walk over the scaled cell
// (one frame store write port, one pixel per cycle) and then the result state.
// Reads, writes, unused opcodes and skipped draws go to result; failed draws pass check.
// Reset clears the control state only; the frame store needs no clearing pass.
// The output register holds a result while out_o stalls; a new transaction is
// taken once the sequencer is idle, even while that result still waits.
`include "scaled_glyph_rasterizer_defines.svh"

module scaled_glyph_rasterizer import sgr_pkg::*; #(
  parameter int FRAME_WIDTH  = FrameWidthDefault,
  parameter int FRAME_HEIGHT = FrameHeightDefault
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  sgr_in_if.sink    in_i,
  sgr_out_if.source out_o
);

  localparam int Pixels = FRAME_WIDTH * FRAME_HEIGHT;
  localparam int AddrW  = $clog2(Pixels);
  localparam int XW     = $clog2(FRAME_WIDTH);
  localparam int YW     = $clog2(FRAME_HEIGHT);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_CHECK  = 3'd1;
  localparam logic [2:0] S_SETUP  = 3'd2;
  localparam logic [2:0] S_WALK   = 3'd3;
  localparam logic [2:0] S_RESULT = 3'd4;

  logic [2:0]           state_q, state_d;
  logic [15:0]          cur_x_q, cur_x_d, cur_y_q, cur_y_d;
  logic [7:0]           ink_q, ink_d, rep_x_q, rep_x_d, rep_y_q, rep_y_d;
  logic                 failed_q, failed_d;
  logic [7:0]           code_q, code_d;
  logic [GlyphIdxW-1:0] glyph_q, glyph_d;
  status_e              res_status_q, res_status_d;
  logic                 res_mem_q, res_mem_d;
  logic                 out_valid_q, out_valid_d;
  logic [2:0]           out_status_q;
  logic [7:0]           out_value_q;

  logic             accept, addr_ok, out_free, out_load;
  logic             host_we, host_re;
  glyph_hit_t       hit;
  logic             fit;
  walk_cmd_t        walk_cmd;
  walk_stat_t       walk_stat;
  logic [AddrW-1:0] walk_base, walk_addr;
  logic             walk_we;
  logic [7:0]       walk_data;
  logic             mem_we;
  logic [AddrW-1:0] mem_waddr;
  logic [7:0]       mem_wdata, mem_rdata;

  assign in_i.ready = (state_q == S_IDLE);
  assign accept     = in_i.valid && in_i.ready;
  assign addr_ok    = (32'(in_i.pixel_addr) < 32'(Pixels));
  assign out_free   = !out_valid_q || out_o.ready;
  assign out_load   = (state_q == S_RESULT) && out_free;

  // Host pixel accesses go straight to the memory in the accept cycle.
  assign host_we = accept && (in_i.opcode == OP_WRITE) && addr_ok;
  assign host_re = accept && (in_i.opcode == OP_READ) && addr_ok;

  assign hit = glyph_find(code_q);
  assign fit = (17'(cur_x_q) + 17'({rep_x_q, 3'b000}) <= 17'(FRAME_WIDTH)) &&
               (17'(cur_y_q) + 17'({rep_y_q, 3'b000}) <= 17'(FRAME_HEIGHT));

  // The cell fits, so the cursor is inside the frame and its low bits suffice.
  assign walk_base = AddrW'(cur_y_q[YW-1:0]) * AddrW'(FRAME_WIDTH) +
                     AddrW'(cur_x_q[XW-1:0]);

  always_comb begin
    walk_cmd       = '0;
    walk_cmd.start = (state_q == S_SETUP);
    walk_cmd.ink   = ink_q;
    walk_cmd.sx    = rep_x_q;
    walk_cmd.sy    = rep_y_q;
    walk_cmd.bits  = GlyphBits[glyph_q];
  end

  always_comb begin
    state_d      = state_q;
    cur_x_d      = cur_x_q;
    cur_y_d      = cur_y_q;
    ink_d        = ink_q;
    rep_x_d      = rep_x_q;
    rep_y_d      = rep_y_q;
    failed_d     = failed_q;
    code_d       = code_q;
    glyph_d      = glyph_q;
    res_status_d = res_status_q;
    res_mem_d    = res_mem_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          res_mem_d    = 1'b0;
          res_status_d = STAT_OK;
          state_d      = S_RESULT;
          case (opcode_e'(in_i.opcode))
            OP_DRAW: begin
              code_d = in_i.char_code;
              if (in_i.first_of_string) begin
                // Load the string context and clear any earlier failure.
                cur_x_d  = in_i.start_x;
                cur_y_d  = in_i.start_y;
                ink_d    = in_i.color;
                rep_x_d  = in_i.scale_x;
                rep_y_d  = in_i.scale_y;
                failed_d = 1'b0;
                state_d  = S_CHECK;
              end else if (failed_q) begin
                res_status_d = STAT_SKIPPED;
              end else begin
                state_d = S_CHECK;
              end
            end
            OP_READ: begin
              res_mem_d    = addr_ok;
              res_status_d = addr_ok ? STAT_OK : STAT_BOUNDS;
            end
            OP_WRITE: begin
              res_status_d = addr_ok ? STAT_OK : STAT_BOUNDS;
            end
            default: begin
              res_status_d = STAT_OK;
            end
          endcase
        end
      end
      S_CHECK: begin
        // Zero scale first, then unknown glyph, then cell bounds.
        state_d = S_RESULT;
        if (rep_x_q == 8'd0 || rep_y_q == 8'd0) begin
          failed_d     = 1'b1;
          res_status_d = STAT_ZERO_SCALE;
        end else if (!hit.hit) begin
          failed_d     = 1'b1;
          res_status_d = STAT_NO_GLYPH;
        end else if (!fit) begin
          failed_d     = 1'b1;
          res_status_d = STAT_BOUNDS;
        end else begin
          glyph_d = hit.idx;
          state_d = S_SETUP;
        end
      end
      S_SETUP: begin
        state_d = S_WALK;
      end
      S_WALK: begin
        if (walk_stat.last) begin
          cur_x_d      = cur_x_q + 16'({rep_x_q, 3'b000});
          res_status_d = STAT_OK;
          state_d      = S_RESULT;
        end
      end
      S_RESULT: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      cur_x_q      <= '0;
      cur_y_q      <= '0;
      ink_q        <= '0;
      rep_x_q      <= 8'd1;
      rep_y_q      <= 8'd1;
      failed_q     <= 1'b0;
      res_status_q <= STAT_OK;
      res_mem_q    <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      cur_x_q      <= cur_x_d;
      cur_y_q      <= cur_y_d;
      ink_q        <= ink_d;
      rep_x_q      <= rep_x_d;
      rep_y_q      <= rep_y_d;
      failed_q     <= failed_d;
      res_status_q <= res_status_d;
      res_mem_q    <= res_mem_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Hold the result payload while the sink stalls.
  always_ff @(posedge clk_i) begin
    code_q  <= code_d;
    glyph_q <= glyph_d;
    if (out_load) begin
      out_status_q <= res_status_q;
      out_value_q  <= res_mem_q ? mem_rdata : 8'd0;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.status      = out_status_q;
  assign out_o.pixel_value = out_value_q;

  sgr_cell_walker #(
    .FRAME_WIDTH (FRAME_WIDTH),
    .ADDR_W      (AddrW)
  ) u_walker (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (walk_cmd),
    .base_i (walk_base),
    .we_o   (walk_we),
    .addr_o (walk_addr),
    .data_o (walk_data),
    .stat_o (walk_stat)
  );

  // The walker and host writes never overlap: host writes happen only in idle.
  assign mem_we    = walk_we || host_we;
  assign mem_waddr = walk_we ? walk_addr : AddrW'(in_i.pixel_addr);
  assign mem_wdata = walk_we ? walk_data : in_i.color;

  sgr_frame_mem #(
    .DEPTH  (Pixels),
    .ADDR_W (AddrW)
  ) u_frame (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (host_re),
    .raddr_i (AddrW'(in_i.pixel_addr)),
    .rdata_o (mem_rdata)
  );

  `SGR_ASSERT(a_no_walk_in_idle, clk_i, rst_ni, (state_q == S_IDLE) |-> !walk_we, "walker writes while idle")
  `SGR_ASSERT(a_ready_not_busy, clk_i, rst_ni, in_i.ready |-> !walk_stat.busy, "ready while walking a cell")
  `SGR_ASSERT_NEXT(a_result_loads, clk_i, rst_ni, out_load, out_valid_q, "result not loaded")
  `SGR_ASSERT_NEXT(a_read_returns, clk_i, rst_ni, host_re, (state_q == S_RESULT) && res_mem_q, "read result lost")

endmodule

// ===== src/sgr_frame_mem.sv =====
module sgr_frame_mem import sgr_pkg::*; #(
  parameter int DEPTH  = FrameWidthDefault * FrameHeightDefault,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [7:0]        wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [7:0]        rdata_o
);

  logic [7:0] mem_q [DEPTH];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/sgr_cell_walker.sv =====
module sgr_cell_walker import sgr_pkg::*; #(
  parameter int FRAME_WIDTH = FrameWidthDefault,
  parameter int ADDR_W      = $clog2(FrameWidthDefault * FrameHeightDefault)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  walk_cmd_t         cmd_i,
  input  logic [ADDR_W-1:0] base_i,
  output logic              we_o,
  output logic [ADDR_W-1:0] addr_o,
  output logic [7:0]        data_o,
  output walk_stat_t        stat_o
);

  logic              active_q, active_d;
  logic [2:0]        row_q, row_d, col_q, col_d;
  logic [7:0]        dy_q, dy_d, dx_q, dx_d;
  logic [7:0]        sx_q, sy_q, ink_q;
  logic [63:0]       bits_q;
  logic [ADDR_W-1:0] pix_q, pix_d, line_q, line_d;
  logic              dx_end, dy_end, line_end, last;

  assign dx_end   = (dx_q == sx_q - 8'd1);
  assign dy_end   = (dy_q == sy_q - 8'd1);
  assign line_end = dx_end && (col_q == 3'd7);
  assign last     = active_q && line_end && dy_end && (row_q == 3'd7);

  always_comb begin
    active_d = active_q;
    row_d    = row_q;
    col_d    = col_q;
    dy_d     = dy_q;
    dx_d     = dx_q;
    pix_d    = pix_q;
    line_d   = line_q;
    if (cmd_i.start) begin
      active_d = 1'b1;
      row_d    = '0;
      col_d    = '0;
      dy_d     = '0;
      dx_d     = '0;
      pix_d    = base_i;
      line_d   = base_i;
    end else if (active_q) begin
      // Raster order over the scaled cell: dx, then col, then dy, then row.
      if (line_end) begin
        dx_d   = '0;
        col_d  = '0;
        line_d = line_q + ADDR_W'(FRAME_WIDTH);
        pix_d  = line_q + ADDR_W'(FRAME_WIDTH);
        if (dy_end) begin
          dy_d = '0;
          row_d = row_q + 3'd1;
          if (row_q == 3'd7) begin
            active_d = 1'b0;
          end
        end else begin
          dy_d = dy_q + 8'd1;
        end
      end else begin
        pix_d = pix_q + ADDR_W'(1);
        if (dx_end) begin
          dx_d  = '0;
          col_d = col_q + 3'd1;
        end else begin
          dx_d = dx_q + 8'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      row_q    <= '0;
      col_q    <= '0;
      dy_q     <= '0;
      dx_q     <= '0;
    end else begin
      active_q <= active_d;
      row_q    <= row_d;
      col_q    <= col_d;
      dy_q     <= dy_d;
      dx_q     <= dx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pix_q  <= pix_d;
    line_q <= line_d;
    if (cmd_i.start) begin
      sx_q   <= cmd_i.sx;
      sy_q   <= cmd_i.sy;
      ink_q  <= cmd_i.ink;
      bits_q <= cmd_i.bits;
    end
  end

  // Write only where the glyph bit is set.
  assign we_o        = active_q && bits_q[{~row_q, ~col_q}];
  assign addr_o      = pix_q;
  assign data_o      = ink_q;
  assign stat_o.busy = active_q;
  assign stat_o.last = last;

endmodule

// ===== bench/sgr_checker.sv =====
`timescale 1ns / 100ps

module sgr_checker import sgr_pkg::*; #(
  parameter int FRAME_WIDTH  = 320,
  parameter int FRAME_HEIGHT = 200
) (
  input  logic clk_i,
  input  logic rst_ni,
  sgr_in_if    in_i,
  sgr_out_if   out_i,
  output int   errors_o,
  output int   pending_o
);

  localparam int Pixels    = FRAME_WIDTH * FRAME_HEIGHT;
  localparam int NumGlyphs = 17;
  localparam int ShowLimit = 10;

  localparam logic [7:0] FontCodes [NumGlyphs] = '{
    8'h20, 8'h43, 8'h45, 8'h52, 8'h54, 8'h61, 8'h64, 8'h65, 8'h68,
    8'h69, 8'h6c, 8'h6d, 8'h6e, 8'h6f, 8'h70, 8'h72, 8'h74
  };

  // Top row in the high byte, leftmost pixel in the MSB of each row.
  localparam logic [63:0] FontRows [NumGlyphs] = '{
    64'h0000000000000000, 64'h3c66c0c0c0663c00, 64'hfe6268786862fe00,
    64'hfc66667c786ce600, 64'hfcb4303030307800, 64'h0000780c7ccc7600,
    64'h1c0c0c7ccccc7600, 64'h000078ccfcc07800, 64'he0606c766666e600,
    64'h3000703030307800, 64'h7030303030307800, 64'h0000ecfed6c6c600,
    64'h0000f8cccccccc00, 64'h000078cccccc7800, 64'h0000dc66667c60f0,
    64'h0000dc766660f000, 64'h10307c3030341800
  };

  typedef struct {
    status_e    status;
    logic [7:0] pixel;
  } raster_result_t;

  raster_result_t pending_results [$];
  logic [7:0]     frame_mem [Pixels];
  logic [15:0]    pen_x;
  logic [15:0]    pen_y;
  logic [7:0]     pen_ink;
  logic [7:0]     rep_x;
  logic [7:0]     rep_y;
  logic           string_dead;
  int             failures = 0;

  assign errors_o = failures;

  // Update the drawing state and the frame copy for one transaction.
  function automatic raster_result_t predict_result(
    input logic [1:0]  op,
    input logic        first,
    input logic [7:0]  code,
    input logic [15:0] x,
    input logic [15:0] y,
    input logic [7:0]  color,
    input logic [7:0]  scx,
    input logic [7:0]  scy,
    input logic [15:0] addr
  );
    raster_result_t res;
    int             glyph;
    logic [63:0]    rows;
    res.status = STAT_OK;
    res.pixel  = '0;
    glyph      = -1;
    case (op)
      OP_DRAW: begin
        if (first) begin
          pen_x       = x;
          pen_y       = y;
          pen_ink     = color;
          rep_x       = scx;
          rep_y       = scy;
          string_dead = 1'b0;
        end
        for (int k = 0; k < NumGlyphs; k++) begin
          if (FontCodes[k] == code) glyph = k;
        end
        if (string_dead) begin
          res.status = STAT_SKIPPED;
        end else if (rep_x == 0 || rep_y == 0) begin
          res.status = STAT_ZERO_SCALE;
        end else if (glyph < 0) begin
          res.status = STAT_NO_GLYPH;
        end else if (int'(pen_x) + 8 * int'(rep_x) > FRAME_WIDTH ||
                     int'(pen_y) + 8 * int'(rep_y) > FRAME_HEIGHT) begin
          res.status = STAT_BOUNDS;
        end else begin
          rows = FontRows[glyph];
          for (int r = 0; r < 8; r++) begin
            for (int c = 0; c < 8; c++) begin
              if (rows[63 - 8 * r - c]) begin
                for (int dy = 0; dy < int'(rep_y); dy++) begin
                  for (int dx = 0; dx < int'(rep_x); dx++) begin
                    frame_mem[(int'(pen_y) + r * int'(rep_y) + dy) * FRAME_WIDTH +
                              int'(pen_x) + c * int'(rep_x) + dx] = pen_ink;
                  end
                end
              end
            end
          end
          pen_x = 16'(int'(pen_x) + 8 * int'(rep_x));
        end
        if (res.status != STAT_OK && res.status != STAT_SKIPPED) string_dead = 1'b1;
      end
      OP_READ: begin
        if (int'(addr) < Pixels) res.pixel = frame_mem[addr];
        else res.status = STAT_BOUNDS;
      end
      OP_WRITE: begin
        if (int'(addr) < Pixels) frame_mem[addr] = color;
        else res.status = STAT_BOUNDS;
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic void log_failure(input string msg);
    if (failures < ShowLimit) $display("%0t: %s", $time, msg);
    failures++;
  endfunction

  initial pending_o = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    raster_result_t want;
    if (!rst_ni) begin
      pen_x       = '0;
      pen_y       = '0;
      pen_ink     = '0;
      rep_x       = 8'd1;
      rep_y       = 8'd1;
      string_dead = 1'b0;
      pending_results.delete();
    end else begin
      // Retire first: a result can never belong to a transaction taken at this edge.
      if (out_i.valid && out_i.ready) begin
        if (pending_results.size() == 0) begin
          log_failure($sformatf("unexpected result: status %0d pixel 0x%02h",
                                out_i.status, out_i.pixel_value));
        end else begin
          want = pending_results.pop_front();
          if (out_i.status !== want.status || out_i.pixel_value !== want.pixel) begin
            log_failure($sformatf(
              "result mismatch: expected status %0d pixel 0x%02h, got status %0d pixel 0x%02h",
              want.status, want.pixel, out_i.status, out_i.pixel_value));
          end
        end
      end
      if (in_i.valid && in_i.ready) begin
        pending_results.push_back(predict_result(in_i.opcode, in_i.first_of_string,
          in_i.char_code, in_i.start_x, in_i.start_y, in_i.color, in_i.scale_x,
          in_i.scale_y, in_i.pixel_addr));
      end
    end
    pending_o = pending_results.size();
  end

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 100ps

module tb;
  import sgr_pkg::*;

  localparam int FrameW = 320;
  localparam int FrameH = 200;
  localparam int Pixels = FrameW * FrameH;

  // Opcode value that the block must answer without doing anything.
  localparam logic [1:0] OpUnused = 2'd3;

  // Longest stretch without any transaction: a full-frame cell walks 64000
  // pixels, so allow several times that.
  localparam int WatchdogLimit = 300000;
  localparam int RandomItems   = 1130;
  localparam int HoldOffCycles = 600;
  localparam int HoldOffAfter  = 40;
  localparam int TailCycles    = 10;

  localparam logic [7:0] CharSpace = 8'h20;
  localparam logic [7:0] CharC     = 8'h43;
  localparam logic [7:0] CharE     = 8'h45;
  localparam logic [7:0] CharH     = 8'h68;
  localparam logic [7:0] CharP     = 8'h70;
  localparam logic [7:0] CharT     = 8'h74;
  localparam logic [7:0] CharBad   = 8'hff;

  localparam logic [7:0] KnownChars [17] = '{
    8'h20, 8'h43, 8'h45, 8'h52, 8'h54, 8'h61, 8'h64, 8'h65, 8'h68,
    8'h69, 8'h6c, 8'h6d, 8'h6e, 8'h6f, 8'h70, 8'h72, 8'h74
  };

  typedef struct {
    logic [1:0]  opcode;
    logic        first;
    logic [7:0]  code;
    logic [15:0] x;
    logic [15:0] y;
    logic [7:0]  color;
    logic [7:0]  scx;
    logic [7:0]  scy;
    logic [15:0] addr;
  } raster_cmd_t;

  logic clk_i;
  logic rst_ni;
  int   errors;
  int   pending;
  int   tx_idle_pct  = 0;
  int   rx_stall_pct = 0;
  logic rx_hold      = 1'b0;
  int   items_sent   = 0;
  int   quiet_cycles = 0;

  // Pixels set by host writes; only these (or out-of-range addresses) are read back,
  // so no read ever touches a never-written location.
  bit pix_written [Pixels];
  int written_addrs [$];

  sgr_in_if  in_ch ();
  sgr_out_if out_ch ();

  scaled_glyph_rasterizer #(
    .FRAME_WIDTH  (FrameW),
    .FRAME_HEIGHT (FrameH)
  ) u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  sgr_checker #(
    .FRAME_WIDTH  (FrameW),
    .FRAME_HEIGHT (FrameH)
  ) u_checker (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_ch),
    .out_i     (out_ch),
    .errors_o  (errors),
    .pending_o (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Result side: stall at the phase rate, and drop ready entirely during the hold-off.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      out_ch.ready <= !rx_hold && ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // Hold off the result side for a long stretch while the sender keeps offering,
  // so the block fills and has to push back on its input.
  initial begin
    wait (items_sent >= HoldOffAfter);
    @(posedge clk_i);
    rx_hold <= 1'b1;
    repeat (HoldOffCycles) @(posedge clk_i);
    rx_hold <= 1'b0;
  end

  // Watchdog: count cycles in which neither channel completes a transaction.
  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchdogLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Fill every field with noise; callers override what the opcode uses.
  function automatic raster_cmd_t rand_cmd();
    raster_cmd_t c;
    c.opcode = 2'($urandom);
    c.first  = 1'($urandom);
    c.code   = 8'($urandom);
    c.x      = 16'($urandom);
    c.y      = 16'($urandom);
    c.color  = 8'($urandom);
    c.scx    = 8'($urandom);
    c.scy    = 8'($urandom);
    c.addr   = 16'($urandom);
    return c;
  endfunction

  function automatic raster_cmd_t draw_first(input logic [7:0] code, input logic [15:0] x,
                                             input logic [15:0] y, input logic [7:0] color,
                                             input logic [7:0] scx, input logic [7:0] scy);
    raster_cmd_t c;
    c        = rand_cmd();
    c.opcode = OP_DRAW;
    c.first  = 1'b1;
    c.code   = code;
    c.x      = x;
    c.y      = y;
    c.color  = color;
    c.scx    = scx;
    c.scy    = scy;
    return c;
  endfunction

  // Continuation character: position, ink and scale fields are ignored, so leave noise.
  function automatic raster_cmd_t draw_next(input logic [7:0] code);
    raster_cmd_t c;
    c        = rand_cmd();
    c.opcode = OP_DRAW;
    c.first  = 1'b0;
    c.code   = code;
    return c;
  endfunction

  function automatic raster_cmd_t host_cmd(input logic [1:0] op, input logic [15:0] addr,
                                           input logic [7:0] data);
    raster_cmd_t c;
    c        = rand_cmd();
    c.opcode = op;
    c.addr   = addr;
    c.color  = data;
    return c;
  endfunction

  // Mostly glyphs from the font, now and then an arbitrary code.
  function automatic logic [7:0] pick_char();
    if ($urandom_range(9) == 0) return 8'($urandom);
    return KnownChars[$urandom_range(16)];
  endfunction

  // Offer one transaction after a random gap and hold it until the block takes it.
  task automatic send_cmd(input raster_cmd_t c);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid           <= 1'b1;
    in_ch.opcode          <= c.opcode;
    in_ch.first_of_string <= c.first;
    in_ch.char_code       <= c.code;
    in_ch.start_x         <= c.x;
    in_ch.start_y         <= c.y;
    in_ch.color           <= c.color;
    in_ch.scale_x         <= c.scx;
    in_ch.scale_y         <= c.scy;
    in_ch.pixel_addr      <= c.addr;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    if (c.opcode == OP_WRITE && int'(c.addr) < Pixels && !pix_written[c.addr]) begin
      pix_written[c.addr] = 1'b1;
      written_addrs.push_back(int'(c.addr));
    end
    items_sent++;
  endtask

  // Random host access: reads go to written pixels or past the frame end,
  // writes land anywhere, a tenth of them out of range.
  task automatic send_host_random();
    logic [15:0] addr;
    if ($urandom_range(1)) begin
      if (written_addrs.size() != 0 && $urandom_range(9) < 8)
        addr = 16'(written_addrs[$urandom_range(written_addrs.size() - 1)]);
      else
        addr = 16'($urandom_range(65535, Pixels));
      send_cmd(host_cmd(OP_READ, addr, 8'($urandom)));
    end else begin
      if ($urandom_range(9) == 0) addr = 16'($urandom_range(65535, Pixels));
      else addr = 16'($urandom_range(Pixels - 1));
      send_cmd(host_cmd(OP_WRITE, addr, 8'($urandom)));
    end
  endtask

  // One string: a start character with mostly sane placement and scale, then
  // up to five more characters, with the odd host access in between.
  task automatic send_string();
    logic [7:0]  scx;
    logic [7:0]  scy;
    logic [15:0] x;
    logic [15:0] y;
    int          r;
    int          len;
    int          lim_x;
    int          lim_y;
    r = $urandom_range(99);
    if (r < 60) begin
      scx = 8'd1;
      scy = 8'd1;
    end else if (r < 85) begin
      scx = 8'($urandom_range(4, 1));
      scy = 8'($urandom_range(4, 1));
    end else if (r < 88) begin
      // Rare big cells keep the run time bounded.
      scx = 8'($urandom_range(20, 5));
      scy = 8'($urandom_range(12, 5));
    end else if (r < 94) begin
      scx = 8'($urandom);
      scy = 8'($urandom);
      if ($urandom_range(1)) scx = '0;
      else scy = '0;
    end else begin
      scx = 8'($urandom);
      scy = 8'($urandom);
    end
    if ($urandom_range(9) == 0) begin
      x = 16'($urandom);
      y = 16'($urandom);
    end else begin
      lim_x = (8 * int'(scx) <= FrameW) ? FrameW - 8 * int'(scx) : FrameW;
      lim_y = (8 * int'(scy) <= FrameH) ? FrameH - 8 * int'(scy) : FrameH;
      x     = 16'($urandom_range(lim_x));
      y     = 16'($urandom_range(lim_y));
    end
    len = $urandom_range(6, 1);
    send_cmd(draw_first(pick_char(), x, y, 8'($urandom), scx, scy));
    for (int k = 1; k < len; k++) begin
      if ($urandom_range(99) < 15) send_host_random();
      send_cmd(draw_next(pick_char()));
    end
  endtask

  initial begin
    raster_cmd_t c;
    int          kind;
    int          phase_end;

    rst_ni                = 1'b0;
    in_ch.valid           = 1'b0;
    in_ch.opcode          = '0;
    in_ch.first_of_string = 1'b0;
    in_ch.char_code       = '0;
    in_ch.start_x         = '0;
    in_ch.start_y         = '0;
    in_ch.color           = '0;
    in_ch.scale_x         = '0;
    in_ch.scale_y         = '0;
    in_ch.pixel_addr      = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Draw before any string start: runs on the reset cursor, ink and scale.
    send_cmd(draw_next(CharC));
    // Host writes at both ends of the frame and just past it.
    send_cmd(host_cmd(OP_WRITE, 16'd0, 8'hff));
    send_cmd(host_cmd(OP_WRITE, 16'(Pixels - 1), 8'ha5));
    send_cmd(host_cmd(OP_WRITE, 16'(Pixels), 8'h00));
    send_cmd(host_cmd(OP_WRITE, 16'hffff, 8'h5a));
    send_cmd(host_cmd(OP_READ, 16'd0, 8'h00));
    send_cmd(host_cmd(OP_READ, 16'hffff, 8'hff));
    send_cmd(host_cmd(OP_READ, 16'(Pixels), 8'h00));
    // Unused opcode: answered, nothing changes.
    c        = rand_cmd();
    c.opcode = OpUnused;
    send_cmd(c);
    // Largest cell: exactly fills the frame, then read back both corners.
    send_cmd(draw_first(CharE, 16'd0, 16'd0, 8'h5a, 8'd40, 8'd25));
    send_cmd(host_cmd(OP_READ, 16'd0, 8'h00));
    send_cmd(host_cmd(OP_READ, 16'(Pixels - 1), 8'h00));
    // Cursor now sits at the right edge: next cell is out of bounds, then skipped.
    send_cmd(draw_next(CharE));
    send_cmd(draw_next(CharC));
    // Zero scale wins over an unknown glyph and a bad position.
    send_cmd(draw_first(CharBad, 16'hffff, 16'hffff, 8'hff, 8'hff, 8'h00));
    send_cmd(draw_next(CharT));
    send_cmd(draw_first(CharC, 16'd0, 16'd0, 8'h01, 8'h00, 8'h01));
    // Unknown glyph is reported before the bounds check.
    send_cmd(draw_first(CharBad, 16'hffff, 16'hffff, 8'h00, 8'hff, 8'hff));
    // Cell that just fits the bottom-right corner; the one after does not.
    send_cmd(draw_first(CharSpace, 16'(FrameW - 8), 16'(FrameH - 8), 8'h81, 8'd1, 8'd1));
    send_cmd(draw_next(CharP));
    // One row too low.
    send_cmd(draw_first(CharP, 16'd0, 16'(FrameH - 7), 8'h42, 8'd1, 8'd1));
    // Scaled string that draws several cells in a row.
    send_cmd(draw_first(CharT, 16'd100, 16'd40, 8'h3c, 8'd2, 8'd3));
    send_cmd(draw_next(CharH));
    send_cmd(draw_next(CharSpace));

    // Random part in four handshake phases: none, sender gaps, receiver
    // stalls, both.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          tx_idle_pct  = 0;
          rx_stall_pct <= 0;
        end
        1: begin
          tx_idle_pct  = 79;
          rx_stall_pct <= 0;
        end
        2: begin
          tx_idle_pct  = 0;
          rx_stall_pct <= 79;
        end
        default: begin
          tx_idle_pct  = 30;
          rx_stall_pct <= 30;
        end
      endcase
      phase_end = items_sent + RandomItems / 4;
      while (items_sent < phase_end) begin
        kind = $urandom_range(99);
        if (kind < 55) begin
          send_string();
        end else if (kind < 93) begin
          send_host_random();
        end else if (kind < 97) begin
          c        = rand_cmd();
          c.opcode = OpUnused;
          send_cmd(c);
        end else begin
          // Stray continuation: keeps going on whatever string state is left.
          send_cmd(draw_next(pick_char()));
        end
      end
    end

    in_ch.valid <= 1'b0;
    // Let the checker log the last transaction before looking at what is still owed.
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== scaled_glyph_rasterizer.f =====
+incdir+src
src/sgr_pkg.sv
src/sgr_in_if.sv
src/sgr_out_if.sv
src/sgr_frame_mem.sv
src/sgr_cell_walker.sv
src/scaled_glyph_rasterizer.sv
bench/sgr_checker.sv
bench/tb.sv
